### rtl/photon_record_timestamp_decoder_macros.svh
// Assertion macros shared by the photon record timestamp decoder sources.
`ifndef PHOTON_RECORD_TIMESTAMP_DECODER_MACROS_SVH
`define PHOTON_RECORD_TIMESTAMP_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold in every cycle outside reset.
`define PRTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PRTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PRTD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/prtd_pkg.sv
// Types and constants shared by the photon record timestamp decoder modules.
package prtd_pkg;

    localparam int RECORD_W    = 32;
    localparam int SYNC_W      = 16;
    localparam int CHAN_W      = 4;
    localparam int FINE_W      = 12;
    localparam int TS_W        = 64;
    localparam int HALF_W      = 32;
    localparam int CHAN_LSB    = 28;
    localparam int FINE_LSB    = 16;
    localparam int TDATA_OUT_W = 72;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [CHAN_W-1:0] SPECIAL_CHANNEL = 4'hF;
    localparam logic [CHAN_W-1:0] ALL_CHANNELS    = 4'hF;
    localparam logic [TS_W-1:0]   WRAP_PERIOD     = 64'd65536;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SYNC_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_CHANNEL_SELECT = 2'd1;
    localparam logic [1:0] REG_RECORD_LIMIT   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [31:0]       sync_interval;
        logic [CHAN_W-1:0] channel_select;
        logic [31:0]       record_limit;
    } cfg_t;

    // One piece of work for the back end: multiplicand, fine time and tags.
    typedef struct packed {
        logic              err;
        logic [CHAN_W-1:0] chan;
        logic [FINE_W-1:0] fine;
        logic [TS_W-1:0]   mult_op;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic        at_limit;
        logic [31:0] records_seen;
    } fr_stat_t;

endpackage

### rtl/prtd_front.sv
// Front end: accepts records, applies the record limit and filter, keeps the counters.
module prtd_front
    import prtd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [RECORD_W-1:0] record_word,
    input  cfg_t                cfg,
    output push_t               push,
    output fr_stat_t            stat
);

    logic [TS_W-1:0]   overflow_base_reg;
    logic [TS_W-1:0]   overflow_base_next;
    logic [31:0]       records_seen_reg;
    logic [31:0]       records_seen_next;
    logic [CHAN_W-1:0] chan;
    logic [FINE_W-1:0] fine;
    logic [SYNC_W-1:0] sync;
    logic              at_limit;
    logic              special;
    logic              pass;

    assign chan = record_word[CHAN_LSB +: CHAN_W];
    assign fine = record_word[FINE_LSB +: FINE_W];
    assign sync = record_word[SYNC_W-1:0];

    // The next count would exceed the limit exactly when the count has reached it.
    assign at_limit = (records_seen_reg >= cfg.record_limit);
    assign special  = (chan == SPECIAL_CHANNEL);
    assign pass     = (cfg.channel_select == ALL_CHANNELS) || (cfg.channel_select == chan);

    always_comb
    begin
        push.valid         = accept && (at_limit || (!special && pass));
        push.entry.err     = at_limit;
        push.entry.chan    = at_limit ? '0 : chan;
        push.entry.fine    = at_limit ? '0 : fine;
        push.entry.mult_op = at_limit ? '0 : overflow_base_reg + TS_W'(sync);
    end

    always_comb
    begin
        records_seen_next  = records_seen_reg;
        overflow_base_next = overflow_base_reg;
        if (accept && !at_limit)
        begin
            records_seen_next = records_seen_reg + 32'd1;
            if (special && (fine == '0))
            begin
                overflow_base_next = overflow_base_reg + WRAP_PERIOD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            records_seen_reg  <= '0;
            overflow_base_reg <= '0;
        end
        else
        begin
            records_seen_reg  <= records_seen_next;
            overflow_base_reg <= overflow_base_next;
        end
    end

    assign stat.at_limit     = at_limit;
    assign stat.records_seen = records_seen_reg;

endmodule

### rtl/prtd_queue.sv
// Short queue in flip-flops between the front and back ends.
module prtd_queue
    import prtd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output head_t   head,
    output q_stat_t stat
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.count = count_reg;
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !stat.full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

### rtl/prtd_back.sv
// Back end: two-stage multiply-accumulate that forms the timestamp, with output register.
module prtd_back
    import prtd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  head_t                  head,
    output logic                   pop,
    input  logic [31:0]            sync_interval,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [TS_W-1:0]        timestamp,
    output logic [CHAN_W-1:0]      photon_channel,
    output logic                   limit_error
);

    logic              s1_valid_reg;
    logic [TS_W-1:0]   prod_lo_reg;
    logic [HALF_W-1:0] prod_hi_reg;
    logic [FINE_W-1:0] s1_fine_reg;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic              s1_err_reg;
    logic              out_valid_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [TS_W-1:0]   ts_next;
    logic [CHAN_W-1:0] out_chan_reg;
    logic              out_err_reg;
    logic              s2_ready;
    logic              s1_ready;
    logic [HALF_W-1:0] hi_full;

    assign s2_ready = !out_valid_reg || m_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = head.valid && s1_ready;

    // Only the low half of the upper partial product reaches the 64-bit result.
    assign hi_full = head.entry.mult_op[TS_W-1:HALF_W] * sync_interval;
    assign ts_next = prod_lo_reg + {prod_hi_reg, {HALF_W{1'b0}}} + TS_W'(s1_fine_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= head.valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_lo_reg <= head.entry.mult_op[HALF_W-1:0] * sync_interval;
            prod_hi_reg <= hi_full;
            s1_fine_reg <= head.entry.fine;
            s1_chan_reg <= head.entry.chan;
            s1_err_reg  <= head.entry.err;
        end
        if (s2_ready && s1_valid_reg)
        begin
            ts_reg       <= ts_next;
            out_chan_reg <= s1_chan_reg;
            out_err_reg  <= s1_err_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign timestamp      = ts_reg;
    assign photon_channel = out_chan_reg;
    assign limit_error    = out_err_reg;

endmodule

### rtl/photon_record_timestamp_decoder.sv
// Top level of the photon record timestamp decoder: registers, front end, queue, back end.
//
//  Channel   Direction  Transaction carries
//  s_axis    in         one 32-bit time-tagged record (tdata[31:0] = record_word)
//  m_axis    out        one result: tdata = timestamp, photon_channel; tuser = limit_error
//  APB       in/out     writes and reads of sync_interval, channel_select, record_limit
//
//  A record is taken in every cycle in which the queue has room, so while m_axis keeps up
//  the sustained rate is one record per clock. A result passes these registers in order:
//  the queue, into which the front end writes its record; the first back-end stage, which
//  forms the two 32 x 32 partial products; the output register, into which the second adds
//  them with the fine time. Reset clears the counters, the queue and all valid flags at
//  once; there is no clearing pass. A stalled m_axis holds the output register and fills
//  the four-entry queue, after which s_axis_tready falls.
`include "photon_record_timestamp_decoder_macros.svh"

module photon_record_timestamp_decoder
    import prtd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input records.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [RECORD_W-1:0]    s_axis_tdata,   // [31:0] record_word
    // Results.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [63:0] timestamp, [67:64] photon_channel,
                                                   // [71:68] zero
    output logic [0:0]             m_axis_tuser,   // [0] limit_error
    // Configuration.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    cfg_t              cfg_reg;
    logic              cfg_write;
    logic [1:0]        reg_index;
    logic              s_accept;
    push_t             push;
    fr_stat_t          fr_stat;
    head_t             head;
    logic              pop;
    q_stat_t           q_stat;
    logic [TS_W-1:0]   timestamp;
    logic [CHAN_W-1:0] photon_channel;
    logic              limit_error;

    // Configuration registers. The register index is the word address, so any byte offset
    // inside a word reaches that word's register; indexes beyond the list are ignored.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_interval  <= '0;
            cfg_reg.channel_select <= ALL_CHANNELS;
            cfg_reg.record_limit   <= '1;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SYNC_INTERVAL:  cfg_reg.sync_interval  <= pwdata;
                REG_CHANNEL_SELECT: cfg_reg.channel_select <= pwdata[CHAN_W-1:0];
                REG_RECORD_LIMIT:   cfg_reg.record_limit   <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SYNC_INTERVAL:  prdata = cfg_reg.sync_interval;
            REG_CHANNEL_SELECT: prdata = PDATA_W'(cfg_reg.channel_select);
            REG_RECORD_LIMIT:   prdata = cfg_reg.record_limit;
            default:            prdata = '0;
        endcase
    end

    // Records are taken whenever the queue can absorb one more entry, whether or not the
    // record turns out to produce a result.
    assign s_axis_tready = !q_stat.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    prtd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .record_word (s_axis_tdata),
        .cfg         (cfg_reg),
        .push        (push),
        .stat        (fr_stat)
    );

    prtd_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    prtd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .sync_interval  (cfg_reg.sync_interval),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .timestamp      (timestamp),
        .photon_channel (photon_channel),
        .limit_error    (limit_error)
    );

    assign m_axis_tdata = {{(TDATA_OUT_W - TS_W - CHAN_W){1'b0}}, photon_channel, timestamp};
    assign m_axis_tuser = limit_error;

    // The queue never holds more entries than it has slots.
    `PRTD_ASSERT(a_queue_bound, clk, rst_n, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

    // A rejected record leaves the record counter as it was.
    `PRTD_ASSERT_NEXT(a_reject_holds_count, clk, rst_n, s_accept && fr_stat.at_limit, fr_stat.records_seen == $past(fr_stat.records_seen), "count moved on rejected record")

    // An error result carries a zero timestamp and channel.
    `PRTD_ASSERT(a_error_zero, clk, rst_n, !(m_axis_tvalid && m_axis_tuser[0]) || (m_axis_tdata == '0), "error result not zero")

    // A photon result never carries the special channel.
    `PRTD_ASSERT(a_photon_channel, clk, rst_n, !(m_axis_tvalid && !m_axis_tuser[0]) || (m_axis_tdata[67:64] != SPECIAL_CHANNEL), "special channel in photon result")

endmodule

### bench/photon_record_timestamp_decoder_test.sv
// Self-checking stream testbench for the photon record timestamp decoder.
`timescale 1ns / 100ps

module photon_record_timestamp_decoder_test;

    import prtd_pkg::*;

    // One decoded photon, or one record rejected by the record limit.
    typedef struct packed {
        logic [TS_W-1:0]   timestamp;
        logic [CHAN_W-1:0] photon_channel;
        logic              limit_error;
    } photon_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [RECORD_W-1:0]    s_axis_tdata = '0;      // [31:0] record_word
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;           // [63:0] timestamp, [67:64] photon_channel
    logic [0:0]             m_axis_tuser;           // [0] limit_error
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    photon_record_timestamp_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Records waiting to be offered, and the results the decoder still owes us.
    logic [RECORD_W-1:0] record_backlog[$];
    photon_result_t      owed_results[$];
    int unsigned         failures = 0;

    // Our own copy of the register file and of the decoder state.
    cfg_t                cfg;
    logic [TS_W-1:0]     overflow_base;
    logic [31:0]         records_seen;

    // Idling controls; a steady side never idles, which gives back-to-back stretches.
    bit                  src_steady = 1'b0;
    bit                  sink_steady = 1'b0;
    int unsigned         src_gap = 0;
    int unsigned         sink_stall = 0;

    function automatic int unsigned idle_length();
        // Mostly short pauses, with the odd long one.
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [RECORD_W-1:0] pack_record(logic [CHAN_W-1:0] chan,
                                                        logic [FINE_W-1:0] fine,
                                                        logic [SYNC_W-1:0] sync);
        return {chan, fine, sync};
    endfunction

    // Work out what one accepted record does to the state and which result it owes.
    task automatic decode_record(input logic [RECORD_W-1:0] word);
        logic [SYNC_W-1:0] sync;
        logic [CHAN_W-1:0] chan;
        logic [FINE_W-1:0] fine;
        photon_result_t    res;
        sync = word[SYNC_W-1:0];
        chan = word[CHAN_LSB +: CHAN_W];
        fine = word[FINE_LSB +: FINE_W];
        // The count is compared one bit wider so that it can never wrap past the limit.
        if ({1'b0, records_seen} + 33'd1 > {1'b0, cfg.record_limit})
        begin
            res = '{timestamp: '0, photon_channel: '0, limit_error: 1'b1};
            owed_results.push_back(res);
        end
        else
        begin
            records_seen = records_seen + 32'd1;
            if (chan == SPECIAL_CHANNEL)
            begin
                // Only an overflow record (markers all zero) moves the time base.
                if (fine == '0)
                begin
                    overflow_base = overflow_base + WRAP_PERIOD;
                end
            end
            else if (cfg.channel_select == ALL_CHANNELS || cfg.channel_select == chan)
            begin
                res.timestamp = TS_W'(fine)
                              + (overflow_base + TS_W'(sync)) * TS_W'(cfg.sync_interval);
                res.photon_channel = chan;
                res.limit_error = 1'b0;
                owed_results.push_back(res);
            end
        end
    endtask

    // Random record: mostly photons on live channels, with special and overflow records mixed in.
    function automatic logic [RECORD_W-1:0] random_record();
        int unsigned       pick;
        logic [RECORD_W-1:0] word;
        pick = $urandom_range(0, 99);
        word = $urandom;
        if (pick < 10)
        begin
            word[CHAN_LSB +: CHAN_W] = SPECIAL_CHANNEL;
            word[FINE_LSB +: FINE_W] = '0;
        end
        else if (pick < 18)
        begin
            word[CHAN_LSB +: CHAN_W] = SPECIAL_CHANNEL;
            word[FINE_LSB +: FINE_W] = FINE_W'($urandom_range(1, 4095));
        end
        else if (pick < 45 && cfg.channel_select != ALL_CHANNELS)
        begin
            // Aim at the selected channel so that filtered runs still give results.
            word[CHAN_LSB +: CHAN_W] = cfg.channel_select;
        end
        else
        begin
            word[CHAN_LSB +: CHAN_W] = CHAN_W'($urandom_range(0, 14));
        end
        return word;
    endfunction

    // Register write: setup cycle then access cycle; the decoder is idle whenever this runs.
    task automatic write_register(input logic [1:0] index, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SYNC_INTERVAL:  cfg.sync_interval  = value;
            REG_CHANNEL_SELECT: cfg.channel_select = value[CHAN_W-1:0];
            REG_RECORD_LIMIT:   cfg.record_limit   = value;
            default: ;
        endcase
    endtask

    // Wait until every record has gone in and every owed result has come out, then let
    // the pipeline run dry, since records without a result may still be in flight.
    task automatic wait_until_drained();
        do
        begin
            @(negedge clk);
        end
        while (!(record_backlog.size() == 0 && !s_axis_tvalid && owed_results.size() == 0));
        repeat (8) @(posedge clk);
    endtask

    // Driver: offers one record per transaction, holds it while tready is low, and
    // inserts random pauses between records.
    always @(posedge clk)
    begin
        logic holding;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_record(s_axis_tdata);
            end
            holding = s_axis_tvalid && !s_axis_tready;
            if (!holding)
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (record_backlog.size() > 0)
                begin
                    s_axis_tdata  <= record_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (!src_steady && $urandom_range(0, 99) < 35)
                    begin
                        src_gap = idle_length();
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest owed result and
    // applies back-pressure at random.
    always @(posedge clk)
    begin
        photon_result_t got;
        photon_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.timestamp      = m_axis_tdata[TS_W-1:0];
            got.photon_channel = m_axis_tdata[TS_W +: CHAN_W];
            got.limit_error    = m_axis_tuser[0];
            if (owed_results.size() == 0)
            begin
                $error("result transaction with nothing owed: timestamp %h channel %0d error %0b",
                       got.timestamp, got.photon_channel, got.limit_error);
                failures++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.timestamp !== want.timestamp)
                begin
                    $error("timestamp: expected %h, actual %h", want.timestamp, got.timestamp);
                    failures++;
                end
                if (got.photon_channel !== want.photon_channel)
                begin
                    $error("photon_channel: expected %0d, actual %0d",
                           want.photon_channel, got.photon_channel);
                    failures++;
                end
                if (got.limit_error !== want.limit_error)
                begin
                    $error("limit_error: expected %0b, actual %0b",
                           want.limit_error, got.limit_error);
                    failures++;
                end
            end
        end
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall = sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 99) < 25)
            begin
                sink_stall = idle_length();
            end
        end
    end

    // Stimulus: directed records first, then random phases under changing settings.
    initial
    begin
        cfg.sync_interval  = '0;
        cfg.channel_select = ALL_CHANNELS;
        cfg.record_limit   = 32'hFFFF_FFFF;
        overflow_base      = '0;
        records_seen       = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes with the largest period, every channel passed.
        write_register(REG_SYNC_INTERVAL, 32'hFFFF_FFFF);
        write_register(REG_CHANNEL_SELECT, PDATA_W'(ALL_CHANNELS));
        write_register(REG_RECORD_LIMIT, 32'hFFFF_FFFF);
        @(negedge clk);
        record_backlog.push_back(32'h0000_0000);
        record_backlog.push_back(pack_record(4'd14, 12'hFFF, 16'hFFFF));
        record_backlog.push_back(pack_record(4'd0, 12'hFFF, 16'h0000));
        record_backlog.push_back(pack_record(4'd7, 12'h000, 16'hFFFF));
        // Overflow records, one of them with a non-zero sync count that must be ignored.
        record_backlog.push_back(pack_record(SPECIAL_CHANNEL, 12'h000, 16'h0000));
        record_backlog.push_back(pack_record(SPECIAL_CHANNEL, 12'h000, 16'hFFFF));
        record_backlog.push_back(pack_record(4'd3, 12'hABC, 16'h1234));
        // Special records with markers set (counted, nothing else), then mixed photon records.
        record_backlog.push_back(pack_record(SPECIAL_CHANNEL, 12'h001, 16'h0000));
        record_backlog.push_back(32'hFFFF_FFFF);
        record_backlog.push_back(pack_record(4'd14, 12'h800, 16'h8000));
        record_backlog.push_back(32'h5555_5555);
        record_backlog.push_back(32'hAAAA_AAAA);
        wait_until_drained();

        // Channel filter, with a zero period so that the timestamp is the fine time alone.
        write_register(REG_SYNC_INTERVAL, 32'd0);
        write_register(REG_CHANNEL_SELECT, 32'd0);
        @(negedge clk);
        record_backlog.push_back(pack_record(4'd0, 12'h123, 16'hFFFF));
        record_backlog.push_back(pack_record(4'd1, 12'h456, 16'h0001));
        record_backlog.push_back(pack_record(4'd14, 12'h789, 16'h0002));
        wait_until_drained();
        write_register(REG_SYNC_INTERVAL, 32'd1);
        write_register(REG_CHANNEL_SELECT, 32'd14);
        @(negedge clk);
        record_backlog.push_back(pack_record(4'd14, 12'hFFF, 16'hFFFF));
        record_backlog.push_back(pack_record(4'd0, 12'h001, 16'h0001));
        wait_until_drained();

        // Record limit: two more records allowed, then rejections that leave the state alone.
        write_register(REG_CHANNEL_SELECT, PDATA_W'(ALL_CHANNELS));
        write_register(REG_RECORD_LIMIT, records_seen + 32'd2);
        @(negedge clk);
        record_backlog.push_back(pack_record(SPECIAL_CHANNEL, 12'h000, 16'h0000));
        record_backlog.push_back(pack_record(4'd2, 12'h010, 16'h0100));
        record_backlog.push_back(pack_record(SPECIAL_CHANNEL, 12'h000, 16'h0000));
        record_backlog.push_back(pack_record(4'd4, 12'hFFF, 16'hFFFF));
        record_backlog.push_back(32'hFFFF_FFFF);
        wait_until_drained();
        write_register(REG_RECORD_LIMIT, 32'd0);
        @(negedge clk);
        record_backlog.push_back(pack_record(4'd1, 12'h001, 16'h0001));
        wait_until_drained();

        // Random phases; each rewrites every register.
        for (int phase = 0; phase < 8; phase++)
        begin
            logic [31:0] period;
            logic [31:0] limit;
            case (phase)
                0:       period = 32'hFFFF_FFFF;
                1:       period = 32'd0;
                2:       period = 32'd1;
                default: period = $urandom;
            endcase
            // One phase runs into the limit part-way through.
            limit = (phase == 5) ? records_seen + $urandom_range(20, 150) : 32'hFFFF_FFFF;
            write_register(REG_SYNC_INTERVAL, period);
            write_register(REG_CHANNEL_SELECT,
                           (phase % 3 == 0) ? PDATA_W'(ALL_CHANNELS) : $urandom_range(0, 15));
            write_register(REG_RECORD_LIMIT, limit);
            src_steady  = (phase == 3);
            sink_steady = (phase == 3) || (phase == 4);
            @(negedge clk);
            repeat (160) record_backlog.push_back(random_record());
            wait_until_drained();
        end

        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("photon_record_timestamp_decoder verification clean");
        end
        else
        begin
            $display("photon_record_timestamp_decoder verification failed");
        end
        $finish;
    end

    // Safety net in case the decoder stops moving transactions altogether.
    initial
    begin
        #5_000_000;
        $display("photon_record_timestamp_decoder verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/prtd_pkg.sv
rtl/prtd_front.sv
rtl/prtd_queue.sv
rtl/prtd_back.sv
rtl/photon_record_timestamp_decoder.sv
bench/photon_record_timestamp_decoder_test.sv
